[rtl/core/byte_pair_block_decoder_macros.svh]
// Assertion macros for the byte pair block decoder.
`ifndef BYTE_PAIR_BLOCK_DECODER_MACROS_SVH
`define BYTE_PAIR_BLOCK_DECODER_MACROS_SVH
`ifndef SYNTHESIS
`define BPBD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("bpbd assertion failed");
`define BPBD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("bpbd assertion failed");
`else
`define BPBD_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define BPBD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[rtl/core/bpbd_pkg.sv]
`default_nettype none
package bpbd_pkg;
	localparam int STACK_DEPTH = 1024;
	localparam int MAX_BLOCKS  = 1 << 20;
	localparam int STK_AW      = $clog2(STACK_DEPTH);
	localparam int LVL_W       = $clog2(STACK_DEPTH + 1);
	localparam int BLK_W       = $clog2(MAX_BLOCKS + 1);

	localparam logic [2:0] PH_BLOCK = 3'd0;
	localparam logic [2:0] PH_COUNT = 3'd1;
	localparam logic [2:0] PH_LEFT  = 3'd2;
	localparam logic [2:0] PH_RIGHT = 3'd3;
	localparam logic [2:0] PH_LENHI = 3'd4;
	localparam logic [2:0] PH_LENLO = 3'd5;
	localparam logic [2:0] PH_BODY  = 3'd6;

	localparam logic [3:0] E_NONE   = 4'd0;
	localparam logic [3:0] E_TABLE  = 4'd1;
	localparam logic [3:0] E_TRUNC  = 4'd2;
	localparam logic [3:0] E_ZERO   = 4'd3;
	localparam logic [3:0] E_STACK  = 4'd4;
	localparam logic [3:0] E_OUTOVF = 4'd5;
	localparam logic [3:0] E_SIZE   = 4'd6;
	localparam logic [3:0] E_BLOCKS = 4'd7;
	localparam logic [3:0] E_MODE   = 4'd8;

	typedef struct packed {
		logic       upd;
		logic       pop;
		logic       push;
		logic [7:0] left;
		logic [7:0] right;
	} stk_cmd_t;

	typedef struct packed {
		logic       two;
		logic [7:0] hi;
		logic [7:0] lo;
	} stk_ent_t;
endpackage
`default_nettype wire

[rtl/core/bpbd_stack.sv]
`default_nettype none
module bpbd_stack import bpbd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  stk_cmd_t   cmd,
	output logic [7:0] nxt_code
);
	stk_ent_t mem [STACK_DEPTH];
	logic [1:0] cnt_q, p_cnt, n_cnt;
	logic [7:0] hi_q, lo_q, p_hi, p_lo, n_hi, n_lo;
	logic [STK_AW-1:0] ent_q, p_ent, n_ent, raddr;
	stk_ent_t rd_q, byp_d_q, wdata, below;
	logic byp_q, we;

	assign below = byp_q ? byp_d_q : rd_q;

	always_comb begin
		p_cnt = cnt_q;
		p_hi  = hi_q;
		p_lo  = lo_q;
		p_ent = ent_q;
		if (cmd.upd && cmd.pop) begin
			if (cnt_q == 2'd2) begin
				p_cnt = 2'd1;
			end else if (ent_q != '0) begin
				p_cnt = below.two ? 2'd2 : 2'd1;
				p_hi  = below.hi;
				p_lo  = below.lo;
				p_ent = ent_q - 1'b1;
			end else begin
				p_cnt = 2'd0;
			end
		end
		wdata = '{two: (p_cnt == 2'd2), hi: p_hi, lo: p_lo};
		we    = 1'b0;
		n_cnt = p_cnt;
		n_hi  = p_hi;
		n_lo  = p_lo;
		n_ent = p_ent;
		if (cmd.upd && cmd.push) begin
			we    = (p_cnt != 2'd0);
			n_ent = we ? p_ent + 1'b1 : p_ent;
			n_cnt = 2'd2;
			n_hi  = cmd.left;
			n_lo  = cmd.right;
		end
		raddr    = n_ent - 1'b1;
		nxt_code = (n_cnt == 2'd2) ? n_hi : n_lo;
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[p_ent] <= wdata;
		end
		rd_q    <= mem[raddr];
		byp_d_q <= wdata;
		hi_q    <= n_hi;
		lo_q    <= n_lo;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			ent_q <= '0;
			byp_q <= 1'b0;
		end else begin
			cnt_q <= n_cnt;
			ent_q <= n_ent;
			byp_q <= we && (p_ent == raddr);
		end
	end
endmodule
`default_nettype wire

[rtl/core/byte_pair_block_decoder.sv]
// Byte pair block decoder.
// Input channel (in_valid/in_ready) carries one item per transfer: mode 0 feeds
// one packed byte (data_byte, last_byte), mode 1 pops and expands one stacked code.
// Result channel (res_valid/res_ready) returns exactly one result per item:
// out_valid/out_byte for a decoded literal, want_byte, done_res and the sticky
// error_code.
// expected_size must be written by the user via cfg_wr_en/cfg_wr_data only while
// the block is idle; the block does not enforce it. Each item passes s1 and s2
// before res_valid; one item is accepted every cycle unless stalled. The table
// lookup is a synchronous pair-table read, and the stack top is kept in registers
// over a one-read, one-write stack memory, so a pop that follows a push in the
// next cycle runs at full rate. When the receiver holds res_ready low with a
// result waiting, the whole pipeline holds and in_ready drops until the result
// is taken. Reset empties the pipeline, clears the stack, pair flags, counters
// and error, and sets expected_size to zero; pair tables need no clearing.
`default_nettype none
`include "byte_pair_block_decoder_macros.svh"
module byte_pair_block_decoder import bpbd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [30:0] cfg_wr_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        mode,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        res_valid,
	input  logic        res_ready,
	output logic        out_valid,
	output logic [7:0]  out_byte,
	output logic        want_byte,
	output logic        done_res,
	output logic [3:0]  error_code
);
	logic [7:0] left_mem [256];
	logic [7:0] right_mem [256];
	logic [255:0] flags_q;

	logic [30:0] exp_q;
	logic [2:0]  phase_q;
	logic [8:0]  slot_q;
	logic [7:0]  run_q;
	logic [15:0] body_q;
	logic [30:0] prod_q;
	logic [BLK_W-1:0] blocks_q;
	logic [3:0]  err_q;
	logic        fin_q;
	logic [LVL_W-1:0] level_q;

	logic s1_v, s1_mode, s1_last;
	logic [7:0] s1_byte;
	logic s2_v, s2_mode, s2_last;
	logic [7:0] s2_byte, s2_code, lrd_s2, rrd_s2;
	logic en;
	logic [7:0] code_s1, nxt_code;
	stk_cmd_t cmd;

	logic [2:0]  n_phase;
	logic [8:0]  n_slot;
	logic [7:0]  n_run;
	logic [15:0] n_body;
	logic [30:0] n_prod;
	logic [BLK_W-1:0] n_blocks;
	logic [3:0]  n_err;
	logic        n_fin;
	logic [LVL_W-1:0] n_level;
	logic        l_wr, r_wr, f_set, f_clr, r_v, upd;
	logic [7:0]  r_b, lft, rgt;

	assign en       = !(res_valid && !res_ready);
	assign in_ready = en;
	assign code_s1  = s1_mode ? nxt_code : s1_byte;
	assign lft      = flags_q[s2_code] ? lrd_s2 : s2_code;
	assign rgt      = flags_q[s2_code] ? rrd_s2 : 8'd0;

	always_comb begin
		logic       tc, do_exp;
		logic [8:0] base, sl1;
		logic [9:0] ts;
		logic [7:0] run, rn;
		logic [15:0] nb;
		tc       = 1'b0;
		do_exp   = 1'b0;
		base     = slot_q;
		sl1      = slot_q + 9'd1;
		rn       = run_q - 8'd1;
		ts       = '0;
		run      = '0;
		nb       = {body_q[15:8], s2_byte};
		n_phase  = phase_q;
		n_slot   = slot_q;
		n_run    = run_q;
		n_body   = body_q;
		n_prod   = prod_q;
		n_blocks = blocks_q;
		n_err    = err_q;
		n_fin    = fin_q;
		n_level  = level_q;
		l_wr     = 1'b0;
		r_wr     = 1'b0;
		f_set    = 1'b0;
		f_clr    = 1'b0;
		r_v      = 1'b0;
		r_b      = 8'd0;
		cmd      = '{upd: 1'b0, pop: 1'b0, push: 1'b0, left: lft, right: rgt};
		if (err_q == E_NONE) begin
			if (!s2_mode) begin
				if (level_q != '0 || fin_q) begin
					n_err = E_MODE;
				end else begin
					case (phase_q)
						PH_BLOCK: begin
							if (blocks_q >= BLK_W'(MAX_BLOCKS)) begin
								n_err = E_BLOCKS;
							end else begin
								n_blocks = blocks_q + 1'b1;
								f_clr    = 1'b1;
								base     = '0;
								tc       = 1'b1;
							end
						end
						PH_COUNT: tc = 1'b1;
						PH_LEFT: begin
							l_wr  = 1'b1;
							f_set = 1'b1;
							if ({1'b0, s2_byte} != slot_q) begin
								n_phase = PH_RIGHT;
							end else begin
								n_slot  = sl1;
								n_run   = rn;
								n_phase = (sl1 >= 9'd256) ? PH_LENHI :
									(rn == 8'd0) ? PH_COUNT : PH_LEFT;
							end
						end
						PH_RIGHT: begin
							r_wr    = 1'b1;
							n_slot  = sl1;
							n_run   = rn;
							n_phase = (sl1 >= 9'd256) ? PH_LENHI :
								(rn == 8'd0) ? PH_COUNT : PH_LEFT;
						end
						PH_LENHI: begin
							n_body  = {s2_byte, 8'd0};
							n_phase = PH_LENLO;
						end
						PH_LENLO: begin
							n_body = nb;
							if (nb == 16'd0) begin
								n_err = E_ZERO;
							end else begin
								n_phase = PH_BODY;
							end
						end
						default: begin
							if (s2_last && body_q > 16'd1) begin
								n_err = E_TRUNC;
							end else begin
								if (body_q != 16'd0) begin
									n_body = body_q - 16'd1;
								end
								do_exp = 1'b1;
							end
						end
					endcase
					if (tc) begin
						ts  = {1'b0, base} + ((s2_byte > 8'd127) ?
							{2'b0, s2_byte - 8'd127} : 10'd0);
						run = (s2_byte > 8'd127) ? 8'd0 : s2_byte;
						if (ts > 10'd256) begin
							n_err = E_TABLE;
						end else if (ts == 10'd256) begin
							n_slot  = ts[8:0];
							n_phase = PH_LENHI;
						end else begin
							n_slot  = ts[8:0];
							n_run   = run + 8'd1;
							n_phase = PH_LEFT;
						end
					end
					if (s2_last) begin
						n_fin = 1'b1;
					end
				end
			end else begin
				if (level_q == '0) begin
					n_err = E_MODE;
				end else begin
					n_level = level_q - 1'b1;
					cmd.pop = 1'b1;
					do_exp  = 1'b1;
				end
			end
			if (do_exp) begin
				if (lft == s2_code) begin
					if (prod_q >= exp_q) begin
						n_err = E_OUTOVF;
					end else begin
						n_prod = prod_q + 31'd1;
						r_v    = 1'b1;
						r_b    = s2_code;
					end
				end else if (n_level > LVL_W'(STACK_DEPTH - 2)) begin
					n_err = E_STACK;
				end else begin
					cmd.push = 1'b1;
					n_level  = n_level + LVL_W'(2);
				end
			end
			if (n_err == E_NONE && n_level == '0) begin
				if (n_phase == PH_BODY && n_body == 16'd0) begin
					n_phase = PH_BLOCK;
				end
				if (n_fin) begin
					if (n_phase != PH_BLOCK) begin
						n_err = E_TRUNC;
					end else if (exp_q == 31'd0 || n_prod != exp_q) begin
						n_err = E_SIZE;
					end
				end
			end
			if (n_err != E_NONE) begin
				r_v = 1'b0;
				r_b = 8'd0;
			end
		end
		upd     = en && s2_v && err_q == E_NONE;
		cmd.upd = upd && n_err == E_NONE;
	end

	bpbd_stack u_stack (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.nxt_code (nxt_code)
	);

	always_ff @(posedge clk) begin
		if (upd && l_wr) begin
			left_mem[slot_q[7:0]] <= s2_byte;
		end
		if (upd && r_wr) begin
			right_mem[slot_q[7:0]] <= s2_byte;
		end
		if (en) begin
			lrd_s2  <= left_mem[code_s1];
			rrd_s2  <= right_mem[code_s1];
			s1_mode <= mode;
			s1_byte <= data_byte;
			s1_last <= last_byte;
			s2_mode <= s1_mode;
			s2_byte <= s1_byte;
			s2_last <= s1_last;
			s2_code <= code_s1;
		end
		if (en && s2_v) begin
			out_valid  <= r_v;
			out_byte   <= r_b;
			want_byte  <= (n_level == '0) && !n_fin && (n_err == E_NONE);
			done_res   <= n_fin && (n_level == '0) && (n_err == E_NONE);
			error_code <= n_err;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_q     <= '0;
			flags_q   <= '0;
			phase_q   <= PH_BLOCK;
			slot_q    <= '0;
			run_q     <= '0;
			body_q    <= '0;
			prod_q    <= '0;
			blocks_q  <= '0;
			err_q     <= E_NONE;
			fin_q     <= 1'b0;
			level_q   <= '0;
			s1_v      <= 1'b0;
			s2_v      <= 1'b0;
			res_valid <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				exp_q <= cfg_wr_data;
			end
			if (en) begin
				s1_v      <= in_valid;
				s2_v      <= s1_v;
				res_valid <= s2_v;
			end
			if (upd) begin
				if (f_clr) begin
					flags_q <= '0;
				end else if (f_set) begin
					flags_q[slot_q[7:0]] <= 1'b1;
				end
				phase_q  <= n_phase;
				slot_q   <= n_slot;
				run_q    <= n_run;
				body_q   <= n_body;
				prod_q   <= n_prod;
				blocks_q <= n_blocks;
				err_q    <= n_err;
				fin_q    <= n_fin;
				level_q  <= n_level;
			end
		end
	end

	`BPBD_ASSERT_NOW(a_stall_holds_input, clk, arst_n, res_valid && !res_ready, !in_ready)
	`BPBD_ASSERT_NEXT(a_error_sticky, clk, arst_n, err_q != E_NONE, err_q == $past(err_q))
	`BPBD_ASSERT_NOW(a_want_done_excl, clk, arst_n, res_valid, !(want_byte && done_res))
	`BPBD_ASSERT_NOW(a_literal_no_error, clk, arst_n, res_valid && out_valid, error_code == E_NONE)
endmodule
`default_nettype wire

[dv/byte_pair_block_decoder_test.sv]
`default_nettype none
module byte_pair_block_decoder_test;
	import bpbd_pkg::*;

	typedef struct {
		logic       lit_valid;
		logic [7:0] lit_byte;
		logic       want;
		logic       done;
		logic [3:0] err;
	} decode_out_t;

	class pair_decode_scoreboard;
		logic [7:0]  left_t [256];
		logic [7:0]  right_t [256];
		bit          flag_t [256];
		logic [7:0]  stack_mem [STACK_DEPTH];
		int          level;
		logic [2:0]  phase;
		int          slot;
		int          run_left;
		int          body_rem;
		int unsigned produced;
		int          blocks;
		logic [3:0]  err;
		bit          finished;
		int unsigned size_limit;
		decode_out_t pending_outputs[$];
		int          mismatches;
		int          items;
		int          literals;

		function new();
			foreach (flag_t[i]) flag_t[i] = 0;
			level = 0;
			phase = PH_BLOCK;
			slot = 0;
			run_left = 0;
			body_rem = 0;
			produced = 0;
			blocks = 0;
			err = E_NONE;
			finished = 0;
			size_limit = 0;
			mismatches = 0;
			items = 0;
			literals = 0;
		endfunction

		function void expand(logic [7:0] c, output logic v, output logic [7:0] ob);
			logic [7:0] l;
			logic [7:0] r;
			l = flag_t[c] ? left_t[c] : c;
			r = flag_t[c] ? right_t[c] : 8'd0;
			v = 0;
			ob = 0;
			if (l == c) begin
				if (produced >= size_limit) begin
					err = E_OUTOVF;
					return;
				end
				produced++;
				v = 1;
				ob = c;
			end else begin
				if (level > STACK_DEPTH - 2) begin
					err = E_STACK;
					return;
				end
				stack_mem[level] = r;
				stack_mem[level + 1] = l;
				level += 2;
			end
		endfunction

		function void next_entry();
			slot++;
			run_left = (run_left - 1) & 255;
			if (slot >= 256)
				phase = PH_LENHI;
			else if (run_left == 0)
				phase = PH_COUNT;
			else
				phase = PH_LEFT;
		endfunction

		function void take_count(logic [7:0] b);
			int run;
			run = b;
			if (b > 127) begin
				slot += b - 127;
				run = 0;
			end
			if (slot > 256) begin
				err = E_TABLE;
				return;
			end
			if (slot == 256) begin
				phase = PH_LENHI;
				return;
			end
			run_left = run + 1;
			phase = PH_LEFT;
		endfunction

		function void feed(logic [7:0] b, bit last, output logic v, output logic [7:0] ob);
			v = 0;
			ob = 0;
			case (phase)
				PH_BLOCK: begin
					if (blocks >= MAX_BLOCKS) begin
						err = E_BLOCKS;
						return;
					end
					blocks++;
					foreach (flag_t[i]) flag_t[i] = 0;
					slot = 0;
					take_count(b);
				end
				PH_COUNT: take_count(b);
				PH_LEFT: begin
					left_t[slot & 255] = b;
					flag_t[slot & 255] = 1;
					if (b != slot)
						phase = PH_RIGHT;
					else
						next_entry();
				end
				PH_RIGHT: begin
					right_t[slot & 255] = b;
					next_entry();
				end
				PH_LENHI: begin
					body_rem = b << 8;
					phase = PH_LENLO;
				end
				PH_LENLO: begin
					body_rem = body_rem | b;
					if (body_rem == 0) begin
						err = E_ZERO;
						return;
					end
					phase = PH_BODY;
				end
				default: begin
					if (last && body_rem > 1) begin
						err = E_TRUNC;
						return;
					end
					if (body_rem > 0)
						body_rem--;
					expand(b, v, ob);
				end
			endcase
		endfunction

		function void note_item(bit m, logic [7:0] b, bit last);
			decode_out_t e;
			logic v;
			logic [7:0] ob;
			v = 0;
			ob = 0;
			items++;
			if (err == E_NONE) begin
				if (!m) begin
					if (level != 0 || finished) begin
						err = E_MODE;
					end else begin
						feed(b, last, v, ob);
						if (last)
							finished = 1;
					end
				end else begin
					if (level == 0) begin
						err = E_MODE;
					end else begin
						level--;
						expand(stack_mem[level], v, ob);
					end
				end
				if (err == E_NONE && level == 0) begin
					if (phase == PH_BODY && body_rem == 0)
						phase = PH_BLOCK;
					if (finished) begin
						if (phase != PH_BLOCK)
							err = E_TRUNC;
						else if (size_limit == 0 || produced != size_limit)
							err = E_SIZE;
					end
				end
				if (err != E_NONE) begin
					v = 0;
					ob = 0;
				end
			end
			if (v)
				literals++;
			e.lit_valid = v;
			e.lit_byte = ob;
			e.want = level == 0 && !finished && err == E_NONE;
			e.done = finished && level == 0 && err == E_NONE;
			e.err = err;
			pending_outputs.push_back(e);
		endfunction

		function void check_result(logic v, logic [7:0] ob, logic w, logic d, logic [3:0] ec);
			decode_out_t e;
			if (pending_outputs.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: valid=%0d byte=%0d err=%0d", v, ob, ec);
				return;
			end
			e = pending_outputs.pop_front();
			if (v !== e.lit_valid || ob !== e.lit_byte || w !== e.want
					|| d !== e.done || ec !== e.err) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch v/b/w/d/e: exp %0d/%0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d/%0d",
						e.lit_valid, e.lit_byte, e.want, e.done, e.err, v, ob, w, d, ec);
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [30:0] cfg_wr_data;
	logic        in_valid;
	logic        in_ready;
	logic        mode;
	logic [7:0]  data_byte;
	logic        last_byte;
	logic        res_valid;
	logic        res_ready;
	logic        out_valid;
	logic [7:0]  out_byte;
	logic        want_byte;
	logic        done_res;
	logic [3:0]  error_code;

	pair_decode_scoreboard sb;
	int tx_max;
	int rx_max;
	int quiet_cycles;
	int glen [256];

	byte_pair_block_decoder uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.mode(mode),
		.data_byte(data_byte),
		.last_byte(last_byte),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.out_valid(out_valid),
		.out_byte(out_byte),
		.want_byte(want_byte),
		.done_res(done_res),
		.error_code(error_code)
	);

	always begin
		clk = 1;
		#5;
		clk = 0;
		#5;
	end

	always @(posedge clk) begin
		if (arst_n && res_valid && res_ready)
			sb.check_result(out_valid, out_byte, want_byte, done_res, error_code);
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (res_valid && res_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= 3000) begin
			$display("timeout: no item moved for %0d cycles", quiet_cycles);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		int w;
		res_ready = 0;
		@(posedge arst_n);
		forever begin
			w = rx_max == 0 ? 0 : $urandom_range(0, rx_max);
			if (w > 0) begin
				@(negedge clk) res_ready <= 0;
				repeat (w - 1) @(negedge clk);
				@(negedge clk) res_ready <= 1;
			end else if (!res_ready) begin
				@(negedge clk) res_ready <= 1;
			end
			do @(posedge clk); while (!(res_valid && res_ready));
		end
	end

	task automatic put_item(bit m, logic [7:0] b, bit last);
		int gap;
		gap = tx_max == 0 ? 0 : $urandom_range(0, tx_max);
		if (gap > 0) begin
			@(negedge clk) in_valid <= 0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1;
		mode <= m;
		data_byte <= b;
		last_byte <= last;
		do @(posedge clk); while (!in_ready);
		sb.note_item(m, b, last);
	endtask

	task automatic send_byte(logic [7:0] b, bit last);
		put_item(0, b, last);
		while (sb.level != 0 && sb.err == E_NONE)
			put_item(1, 8'($urandom), 1'($urandom));
	endtask

	task automatic settle();
		@(negedge clk) in_valid <= 0;
		while (sb.pending_outputs.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_size(logic [30:0] value);
		settle();
		@(negedge clk);
		cfg_wr_en <= 1;
		cfg_wr_data <= value;
		@(negedge clk) cfg_wr_en <= 0;
		sb.size_limit = value;
	endtask

	task automatic table_entry(int s);
		int l;
		int r;
		if (s == 0 || $urandom_range(0, 2) == 0) begin
			send_byte(8'(s), 0);
			glen[s] = 1;
			return;
		end
		l = $urandom_range(0, s - 1);
		r = $urandom_range(0, s - 1);
		if (glen[l] + glen[r] > 12) begin
			send_byte(8'(s), 0);
			glen[s] = 1;
			return;
		end
		send_byte(8'(l), 0);
		send_byte(8'(r), 0);
		glen[s] = glen[l] + glen[r];
	endtask

	task automatic random_block(bit final_blk);
		int s;
		int k;
		int n;
		logic [7:0] c;
		foreach (glen[i]) glen[i] = 1;
		s = 0;
		while (s < 256) begin
			if ($urandom_range(0, 9) < 7) begin
				k = $urandom_range(1, (256 - s) < 128 ? 256 - s : 128);
				send_byte(8'(127 + k), 0);
				s += k;
				if (s == 256)
					break;
				table_entry(s);
				s++;
			end else begin
				n = $urandom_range(1, (256 - s) < 6 ? 256 - s : 6);
				send_byte(8'(n - 1), 0);
				repeat (n) begin
					table_entry(s);
					s++;
				end
			end
		end
		n = $urandom_range(0, 39) == 0 ? 256 + $urandom_range(0, 20) : $urandom_range(1, 12);
		send_byte(8'(n >> 8), 0);
		send_byte(8'(n), 0);
		for (int i = 0; i < n; i++) begin
			c = 8'($urandom);
			if (final_blk && i == n - 1) begin
				write_size(31'(sb.produced + glen[c]));
				send_byte(c, 1);
			end else begin
				send_byte(c, 0);
			end
		end
	endtask

	initial begin
		logic [7:0] directed [$];
		sb = new();
		quiet_cycles = 0;
		tx_max = 0;
		rx_max = 0;
		arst_n = 0;
		cfg_wr_en = 0;
		cfg_wr_data = 0;
		in_valid = 0;
		mode = 0;
		data_byte = 0;
		last_byte = 0;
		repeat (2) @(posedge clk);
		@(negedge clk) arst_n <= 1;
		write_size(31'h7FFF_FFFF);

		directed = '{8'h00, 8'h00, 8'h81, 8'h00, 8'hFF, 8'hFF, 8'h84, 8'hFA,
			8'h00, 8'h04, 8'h03, 8'hFF, 8'h84, 8'h00,
			8'hFF, 8'h80, 8'hFE, 8'h00, 8'h01, 8'h80};
		foreach (directed[i])
			send_byte(directed[i], 0);

		while (sb.items < 1400 && sb.err == E_NONE) begin
			tx_max = $urandom_range(0, 1) ? 16 : 0;
			rx_max = $urandom_range(0, 1) ? 16 : 0;
			if ($urandom_range(0, 9) == 0)
				write_size(31'($urandom_range(100000, 32'h7FFF_FFFF)));
			random_block(0);
		end
		random_block(1);

		repeat (50)
			put_item(1'($urandom), 8'($urandom), 1'($urandom));
		write_size(31'd0);
		settle();

		$display("decoded %0d items over %0d blocks, %0d literal bytes, final error %0d",
			sb.items, sb.blocks, sb.literals, sb.err);
		if (sb.mismatches == 0 && sb.pending_outputs.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule
`default_nettype wire
